[rtl/core/lc3_pkg.sv]
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared opcodes, trap vectors and controller/datapath command types.
// ----------------------------------------------------------------------------
package lc3_pkg;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_RTI  = 4'h8;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_STI  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_RES  = 4'hD;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    localparam logic [7:0] TRAP_GETC = 8'h20;
    localparam logic [7:0] TRAP_OUT  = 8'h21;
    localparam logic [7:0] TRAP_IN   = 8'h23;
    localparam logic [7:0] TRAP_HALT = 8'h25;

    localparam logic [15:0] KBSR_ADDR = 16'hFE00;
    localparam logic [15:0] KBDR_ADDR = 16'hFE02;

    localparam logic [2:0] CC_P = 3'd1;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_N = 3'd4;

    // memory address source
    typedef enum logic [1:0] {
        ASEL_PC   = 2'd0,
        ASEL_EA   = 2'd1,
        ASEL_MDR  = 2'd2,
        ASEL_LOAD = 2'd3
    } asel_t;

    // controller to datapath
    typedef struct packed {
        logic  capture;   // latch input item
        logic  mem_rd;    // read at selected address
        logic  mem_wr;    // write at selected address
        asel_t asel;
        logic  wr_load;   // write data is load word (else register)
        logic  ir_load;   // instruction register takes read data
        logic  mdr_load;  // data register takes read data
        logic  execute;   // commit register/pc/cc update
        logic  clr_clear; // advance clearing sweep
    } lc3_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [3:0] opcode;
        logic       clr_done;
    } lc3_stat_t;

endpackage

[rtl/core/lc3_datapath.sv]
// ----------------------------------------------------------------------------
// lc3_datapath
// Memory, register file, pc, condition codes and instruction execution.
// ----------------------------------------------------------------------------
module lc3_datapath
    import lc3_pkg::*;
#(
    parameter int ADDR_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lc3_cmd_t    cmd,
    output lc3_stat_t   stat,
    input  logic [15:0] in_address,
    input  logic [15:0] in_data,
    input  logic        in_key_valid,
    input  logic [7:0]  in_key_char,
    output logic [15:0] program_counter,
    output logic [2:0]  condition,
    output logic        out_valid,
    output logic [7:0]  out_char,
    output logic        halted,
    output logic        fault
);

    localparam int MEM_DEPTH = 1 << ADDR_WIDTH;

    logic [15:0] mem [MEM_DEPTH];
    logic [15:0] rf_reg [8];

    logic [15:0] addr_reg, data_reg;
    logic        kv_reg;
    logic [7:0]  kc_reg;
    logic [15:0] ir_reg, mdr_reg, rd_data;
    logic [15:0] pc_reg;
    logic [2:0]  cc_reg;
    logic        halt_reg, fault_reg, ov_reg;
    logic [7:0]  oc_reg;
    logic [ADDR_WIDTH:0] clr_reg;

    logic [15:0] pc1, sr1v, drv, op2, off9, off6, ea, mem_addr, wr_data;
    logic [ADDR_WIDTH-1:0] mem_idx;
    logic [ADDR_WIDTH-1:0] kbsr_idx, kbdr_idx;
    logic        kb_hit;

    assign kbsr_idx = KBSR_ADDR[ADDR_WIDTH-1:0];
    assign kbdr_idx = KBDR_ADDR[ADDR_WIDTH-1:0];

    // decode fields
    assign pc1  = pc_reg + 16'd1;
    assign sr1v = rf_reg[ir_reg[8:6]];
    assign drv  = rf_reg[ir_reg[11:9]];
    assign op2  = ir_reg[5] ? {{11{ir_reg[4]}}, ir_reg[4:0]} : rf_reg[ir_reg[2:0]];
    assign off9 = {{7{ir_reg[8]}}, ir_reg[8:0]};
    assign off6 = {{10{ir_reg[5]}}, ir_reg[5:0]};
    assign ea   = (ir_reg[15:12] == OP_LDR || ir_reg[15:12] == OP_STR)
                  ? sr1v + off6 : pc1 + off9;

    // address and write data selection
    always_comb
    begin
        case (cmd.asel)
            ASEL_PC:   mem_addr = pc_reg;
            ASEL_EA:   mem_addr = ea;
            ASEL_MDR:  mem_addr = mdr_reg;
            default:   mem_addr = addr_reg;
        endcase
    end
    assign mem_idx = cmd.clr_clear ? clr_reg[ADDR_WIDTH-1:0] : mem_addr[ADDR_WIDTH-1:0];
    assign wr_data = cmd.clr_clear ? 16'd0 : (cmd.wr_load ? data_reg : drv);
    assign kb_hit  = cmd.mem_rd && (mem_addr == KBSR_ADDR);

    // memory: one access per cycle, keyboard sample on status read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr || cmd.clr_clear)
        begin
            mem[mem_idx] <= wr_data;
        end
        else if (kb_hit)
        begin
            mem[kbsr_idx] <= kv_reg ? 16'h8000 : 16'h0000;
            if (kv_reg)
            begin
                mem[kbdr_idx] <= {8'd0, kc_reg};
            end
        end
        if (cmd.mem_rd)
        begin
            rd_data <= mem[mem_idx];
        end
    end

    // a status read returns the freshly sampled value until the next read
    logic        kb_last_reg;
    logic [15:0] rd_word;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kb_last_reg <= 1'b0;
        end
        else if (cmd.mem_rd)
        begin
            kb_last_reg <= kb_hit;
        end
    end
    assign rd_word = kb_last_reg ? (kv_reg ? 16'h8000 : 16'h0000) : rd_data;

    // item capture and instruction/data registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= in_address;
            data_reg <= in_data;
            kv_reg   <= in_key_valid;
            kc_reg   <= in_key_char;
        end
        if (cmd.ir_load)
        begin
            ir_reg <= rd_word;
        end
        if (cmd.mdr_load)
        begin
            mdr_reg <= rd_word;
        end
    end

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_clear)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end
    assign stat.clr_done = clr_reg[ADDR_WIDTH];
    assign stat.opcode   = ir_reg[15:12];

    // execute: architectural state update
    logic [15:0] res;
    logic        wr_rf, set_cc, is_key, key_ok;
    logic [2:0]  wr_dst;
    logic [15:0] pc_next;
    always_comb
    begin
        res     = 16'd0;
        wr_rf   = 1'b0;
        set_cc  = 1'b0;
        wr_dst  = ir_reg[11:9];
        pc_next = pc1;
        is_key  = (ir_reg[7:0] == TRAP_GETC) || (ir_reg[7:0] == TRAP_IN);
        key_ok  = kv_reg;
        unique case (ir_reg[15:12])
            OP_BR:
            begin
                if ((ir_reg[11:9] & cc_reg) != 3'd0)
                begin
                    pc_next = pc1 + off9;
                end
            end
            OP_ADD:
            begin
                res = sr1v + op2; wr_rf = 1'b1; set_cc = 1'b1;
            end
            OP_AND:
            begin
                res = sr1v & op2; wr_rf = 1'b1; set_cc = 1'b1;
            end
            OP_NOT:
            begin
                res = ~sr1v; wr_rf = 1'b1; set_cc = 1'b1;
            end
            OP_JMP:
            begin
                pc_next = sr1v;
            end
            OP_JSR:
            begin
                res = pc1; wr_rf = 1'b1; wr_dst = 3'd7;
                pc_next = ir_reg[11] ? pc1 + {{5{ir_reg[10]}}, ir_reg[10:0]} : sr1v;
            end
            OP_LD, OP_LDR, OP_LDI:
            begin
                res = rd_word; wr_rf = 1'b1; set_cc = 1'b1;
            end
            OP_LEA:
            begin
                res = pc1 + off9; wr_rf = 1'b1; set_cc = 1'b1;
            end
            OP_TRAP:
            begin
                if (is_key)
                begin
                    if (key_ok)
                    begin
                        res = {8'd0, kc_reg}; wr_rf = 1'b1; wr_dst = 3'd0;
                    end
                    else
                    begin
                        pc_next = pc_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            cc_reg    <= '0;
            halt_reg  <= 1'b0;
            fault_reg <= 1'b0;
            ov_reg    <= 1'b0;
            oc_reg    <= '0;
            for (int i = 0; i < 8; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (cmd.capture)
        begin
            fault_reg <= 1'b0;
            ov_reg    <= 1'b0;
            oc_reg    <= '0;
        end
        else if (cmd.execute)
        begin
            pc_reg <= pc_next;
            if (wr_rf)
            begin
                rf_reg[wr_dst] <= res;
            end
            if (set_cc)
            begin
                cc_reg <= (res == 16'd0) ? CC_Z : (res[15] ? CC_N : CC_P);
            end
            if (ir_reg[15:12] == OP_RTI || ir_reg[15:12] == OP_RES)
            begin
                fault_reg <= 1'b1;
            end
            if (ir_reg[15:12] == OP_TRAP)
            begin
                if (ir_reg[7:0] == TRAP_HALT)
                begin
                    halt_reg <= 1'b1;
                end
                if (ir_reg[7:0] == TRAP_OUT)
                begin
                    ov_reg <= 1'b1;
                    oc_reg <= rf_reg[0][7:0];
                end
                if (ir_reg[7:0] == TRAP_IN && kv_reg)
                begin
                    ov_reg <= 1'b1;
                    oc_reg <= kc_reg;
                end
            end
        end
    end

    assign program_counter = pc_reg;
    assign condition       = cc_reg;
    assign out_valid       = ov_reg;
    assign out_char        = oc_reg;
    assign halted          = halt_reg;
    assign fault           = fault_reg;

endmodule

[rtl/core/lc3_control.sv]
// ----------------------------------------------------------------------------
// lc3_control
// Sequencer: clearing sweep, handshake, fetch, memory phases, execute.
// ----------------------------------------------------------------------------
module lc3_control
    import lc3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      command,
    input  logic      halted,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  lc3_stat_t stat,
    output lc3_cmd_t  cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_LOAD  = 10'b0000000100,
        ST_FETCH = 10'b0000001000,
        ST_FWAIT = 10'b0000010000,
        ST_DECODE= 10'b0000100000,
        ST_IND   = 10'b0001000000,
        ST_DATA  = 10'b0010000000,
        ST_EXEC  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ind_reg, ind_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        ind_next   = ind_reg;
        cmd        = '0;
        cmd.asel   = ASEL_PC;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_clear = 1'b1;
                if (stat.clr_done)
                begin
                    cmd.clr_clear = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next = !command ? ST_LOAD : (halted ? ST_OUT : ST_FETCH);
                end
            end
            ST_LOAD:
            begin
                cmd.asel = ASEL_LOAD; cmd.wr_load = 1'b1; cmd.mem_wr = 1'b1;
                state_next = ST_OUT;
            end
            ST_FETCH:
            begin
                cmd.asel = ASEL_PC; cmd.mem_rd = 1'b1;
                state_next = ST_FWAIT;
            end
            ST_FWAIT:
            begin
                cmd.ir_load = 1'b1;
                state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                // issue the first data access
                ind_next = 1'b0;
                unique case (stat.opcode)
                    OP_LD, OP_LDR:
                    begin
                        cmd.asel = ASEL_EA; cmd.mem_rd = 1'b1;
                        state_next = ST_DATA;
                    end
                    OP_LDI, OP_STI:
                    begin
                        cmd.asel = ASEL_EA; cmd.mem_rd = 1'b1;
                        state_next = ST_IND;
                    end
                    OP_ST, OP_STR:
                    begin
                        cmd.asel = ASEL_EA; cmd.mem_wr = 1'b1;
                        state_next = ST_EXEC;
                    end
                    default:
                    begin
                        state_next = ST_EXEC;
                    end
                endcase
            end
            ST_IND:
            begin
                cmd.mdr_load = 1'b1;
                ind_next = 1'b1;
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (ind_reg)
                begin
                    // second access through pointer
                    cmd.asel = ASEL_MDR;
                    if (stat.opcode == OP_STI)
                    begin
                        cmd.mem_wr = 1'b1;
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        cmd.mem_rd = 1'b1;
                        ind_next = 1'b0;
                    end
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ind_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ind_reg   <= ind_next;
        end
    end

endmodule

[rtl/core/lc3_instruction_step_core.sv]
// ----------------------------------------------------------------------------
// lc3_instruction_step_core
// LC-3 processor core stepped one instruction per input transfer.
// ----------------------------------------------------------------------------
// After reset the core sweeps its 2^ADDR_WIDTH-word memory to zero, one word
// per cycle, and accepts nothing until done.
// A load transfer writes memory before its result is offered. A step fetches,
// makes each data access in turn on the single-port memory (one for LD, LDR,
// ST and STR, two for LDI and STI), then executes; while halted a step does
// nothing and goes straight to its result. One item is in flight at a time.
module lc3_instruction_step_core
    import lc3_pkg::*;
#(
    parameter int ADDR_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[0], address[16:1], data[32:17], key_valid[33], key_char[41:34], 0
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // program_counter[15:0], condition[18:16], out_valid[19], out_char[27:20],
    // halted[28], fault[29], 0
    output logic [31:0] m_tdata
);

    lc3_cmd_t    cmd;
    lc3_stat_t   stat;
    logic [15:0] pc;
    logic [2:0]  cc;
    logic        ov, hl, ft;
    logic [7:0]  oc;

    lc3_control u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tdata[0]),
        .halted   (hl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lc3_datapath #(.ADDR_WIDTH(ADDR_WIDTH)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_address      (s_tdata[16:1]),
        .in_data         (s_tdata[32:17]),
        .in_key_valid    (s_tdata[33]),
        .in_key_char     (s_tdata[41:34]),
        .program_counter (pc),
        .condition       (cc),
        .out_valid       (ov),
        .out_char        (oc),
        .halted          (hl),
        .fault           (ft)
    );

    assign m_tdata = {2'b00, ft, hl, oc, ov, cc, pc};

endmodule

[test/tb_lc3_instruction_step_core.sv]
// ----------------------------------------------------------------------------
// tb_lc3_instruction_step_core
// Self-checking bench for the stepped LC-3 core.
// ----------------------------------------------------------------------------
// Items are built up front together with a software copy of the processor
// (memory, registers, pc, condition codes, halt flag), which gives the
// expected result of every transfer. Programs are written one instruction
// at a time at the predicted pc and then stepped, so every opcode, trap and
// keyboard access runs with random content. Both stream sides idle in
// random bursts, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lc3_instruction_step_core;
    import lc3_pkg::*;

    typedef struct packed {
        logic [15:0] pc;
        logic [2:0]  cc;
        logic        ov;
        logic [7:0]  oc;
        logic        hlt;
        logic        flt;
    } step_result_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;
    localparam logic [7:0] TRAP_PUTS = 8'h22;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    // pending input words and expected results
    logic [47:0]  pending_items[$];
    step_result_t expected_results[$];
    int           mismatch_count;
    int           accepted_results;
    logic         stimulus_built;

    // software copy of the processor
    logic [15:0] cpu_mem[0:65535];
    logic [15:0] cpu_reg[0:7];
    logic [15:0] cpu_pc;
    logic [2:0]  cpu_cc;
    logic        cpu_halt;

    lc3_instruction_step_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what);
    begin
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    end
    endtask

    // memory read with keyboard status sampling
    function automatic logic [15:0] cpu_read(input logic [15:0] a, input logic kv,
                                             input logic [7:0] kc);
    begin
        if (a == KBSR_ADDR)
        begin
            cpu_mem[KBSR_ADDR] = kv ? 16'h8000 : 16'h0000;
            if (kv)
                cpu_mem[KBDR_ADDR] = {8'h00, kc};
        end
        return cpu_mem[a];
    end
    endfunction

    function automatic logic [2:0] cc_of(input logic [15:0] v);
    begin
        if (v == 16'h0000)
            return CC_Z;
        else if (v[15])
            return CC_N;
        return CC_P;
    end
    endfunction

    // advance the processor copy by one item and queue the transfer
    task automatic issue_item(input logic cmd, input logic [15:0] addr,
                              input logic [15:0] wdata, input logic kv,
                              input logic [7:0] kc);
        step_result_t r;
        logic [15:0]  ins, at, off9, off6, op2, t;
        logic [2:0]   dr, sr1;
    begin
        r = '0;
        if (cmd == CMD_LOAD)
            cpu_mem[addr] = wdata;
        else if (!cpu_halt)
        begin
            at   = cpu_pc;
            ins  = cpu_read(at, kv, kc);
            dr   = ins[11:9];
            sr1  = ins[8:6];
            off9 = {{7{ins[8]}}, ins[8:0]};
            off6 = {{10{ins[5]}}, ins[5:0]};
            op2  = ins[5] ? {{11{ins[4]}}, ins[4:0]} : cpu_reg[ins[2:0]];
            cpu_pc = at + 16'd1;
            case (ins[15:12])
                OP_BR:
                    if ((ins[11:9] & cpu_cc) != 3'd0)
                        cpu_pc = cpu_pc + off9;
                OP_ADD:
                begin
                    cpu_reg[dr] = cpu_reg[sr1] + op2;
                    cpu_cc = cc_of(cpu_reg[dr]);
                end
                OP_AND:
                begin
                    cpu_reg[dr] = cpu_reg[sr1] & op2;
                    cpu_cc = cc_of(cpu_reg[dr]);
                end
                OP_NOT:
                begin
                    cpu_reg[dr] = ~cpu_reg[sr1];
                    cpu_cc = cc_of(cpu_reg[dr]);
                end
                OP_JMP:
                    cpu_pc = cpu_reg[sr1];
                OP_JSR:
                begin
                    t = ins[11] ? cpu_pc + {{5{ins[10]}}, ins[10:0]} : cpu_reg[sr1];
                    cpu_reg[7] = cpu_pc;
                    cpu_pc = t;
                end
                OP_LD:
                begin
                    cpu_reg[dr] = cpu_read(cpu_pc + off9, kv, kc);
                    cpu_cc = cc_of(cpu_reg[dr]);
                end
                OP_LDI:
                begin
                    t = cpu_read(cpu_pc + off9, kv, kc);
                    cpu_reg[dr] = cpu_read(t, kv, kc);
                    cpu_cc = cc_of(cpu_reg[dr]);
                end
                OP_LDR:
                begin
                    cpu_reg[dr] = cpu_read(cpu_reg[sr1] + off6, kv, kc);
                    cpu_cc = cc_of(cpu_reg[dr]);
                end
                OP_LEA:
                begin
                    cpu_reg[dr] = cpu_pc + off9;
                    cpu_cc = cc_of(cpu_reg[dr]);
                end
                OP_ST:
                    cpu_mem[cpu_pc + off9] = cpu_reg[dr];
                OP_STI:
                begin
                    t = cpu_read(cpu_pc + off9, kv, kc);
                    cpu_mem[t] = cpu_reg[dr];
                end
                OP_STR:
                    cpu_mem[cpu_reg[sr1] + off6] = cpu_reg[dr];
                OP_TRAP:
                    case (ins[7:0])
                        TRAP_GETC, TRAP_IN:
                            if (!kv)
                                cpu_pc = at;
                            else
                            begin
                                cpu_reg[0] = {8'h00, kc};
                                if (ins[7:0] == TRAP_IN)
                                begin
                                    r.ov = 1'b1;
                                    r.oc = kc;
                                end
                            end
                        TRAP_OUT:
                        begin
                            r.ov = 1'b1;
                            r.oc = cpu_reg[0][7:0];
                        end
                        TRAP_HALT:
                            cpu_halt = 1'b1;
                        default: ;
                    endcase
                default:
                    r.flt = 1'b1;
            endcase
        end
        r.pc  = cpu_pc;
        r.cc  = cpu_cc;
        r.hlt = cpu_halt;
        expected_results.push_back(r);
        pending_items.push_back({6'b0, kc, kv, wdata, addr, cmd});
    end
    endtask

    // write an instruction at the predicted pc and step it
    task automatic run_instr(input logic [15:0] ins, input logic kv, input logic [7:0] kc);
    begin
        issue_item(CMD_LOAD, cpu_pc, ins, 1'($urandom_range(0, 1)), 8'($urandom));
        issue_item(CMD_STEP, 16'($urandom), 16'($urandom), kv, kc);
    end
    endtask

    function automatic logic [15:0] random_instr();
        logic [15:0] ins;
        logic [7:0]  vec;
    begin
        ins = 16'($urandom);
        if (ins[15:12] == OP_TRAP)
        begin
            case ($urandom_range(0, 5))
                0: vec = TRAP_GETC;
                1: vec = TRAP_IN;
                2: vec = TRAP_OUT;
                3: vec = TRAP_PUTS;
                default: vec = 8'($urandom);
            endcase
            if (vec == TRAP_HALT)
                vec = TRAP_OUT;
            ins[11:0] = {4'h0, vec};
        end
        return ins;
    end
    endfunction

    // stimulus and expected results
    initial
    begin : build_stimulus
        logic [15:0] ins, dptr, dval;
        stimulus_built = 1'b0;
        for (int i = 0; i < 65536; i++)
            cpu_mem[i] = 16'h0000;
        for (int i = 0; i < 8; i++)
            cpu_reg[i] = 16'h0000;
        cpu_pc = 16'h0000;
        cpu_cc = 3'd0;
        cpu_halt = 1'b0;

        // directed: arithmetic, branches, memory, keyboard, traps, faults
        run_instr(16'h127F, 1'b0, 8'h00);                 // add imm, negative
        run_instr(16'h5460, 1'b0, 8'h00);                 // and to zero
        run_instr(16'h1641, 1'b0, 8'h00);                 // add reg
        run_instr(16'h9840, 1'b0, 8'h00);                 // not
        run_instr(16'h14AF, 1'b0, 8'h00);                 // positive
        run_instr(16'h0E00, 1'b0, 8'h00);                 // br nzp
        run_instr(16'hEB00, 1'b0, 8'h00);                 // lea far back
        run_instr(16'h3201, 1'b0, 8'h00);                 // st
        run_instr(16'h2C00, 1'b0, 8'h00);                 // ld of stored word
        run_instr(16'h6041, 1'b0, 8'h00);                 // ldr wraps to 0
        run_instr(16'h757F, 1'b0, 8'h00);                 // str
        issue_item(CMD_LOAD, cpu_pc + 16'd2, KBSR_ADDR, 1'b0, 8'h00);
        run_instr(16'hAE01, 1'b1, 8'hA5);                 // ldi of status, key
        issue_item(CMD_LOAD, cpu_pc + 16'd2, KBDR_ADDR, 1'b0, 8'h00);
        run_instr(16'hAE01, 1'b1, 8'hFF);                 // ldi of key data
        run_instr(16'hF020, 1'b0, 8'h00);                 // getc waits
        issue_item(CMD_STEP, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
        run_instr(16'hF023, 1'b1, 8'h41);                 // in echoes
        run_instr(16'hF021, 1'b0, 8'h00);                 // out
        run_instr({OP_TRAP, 4'h0, TRAP_PUTS}, 1'b0, 8'h00);
        run_instr({OP_RTI, 12'h000}, 1'b0, 8'h00);        // faults
        run_instr({OP_RES, 12'hFFF}, 1'b0, 8'h00);
        run_instr(16'h4802, 1'b0, 8'h00);                 // jsr
        run_instr(16'h4040, 1'b0, 8'h00);                 // jsrr to r1 contents
        run_instr(16'hC1C0, 1'b0, 8'h00);                 // jmp r7
        // fetch from the keyboard status word itself
        issue_item(CMD_LOAD, cpu_pc + 16'd1, KBSR_ADDR, 1'b0, 8'h00);
        run_instr(16'h2000, 1'b0, 8'h00);
        run_instr(16'hC000, 1'b0, 8'h00);
        issue_item(CMD_STEP, 16'h0000, 16'h0000, 1'b1, 8'h7E);

        // random programs with random content, plus some noise
        while (pending_items.size() < 1380)
        begin
            case ($urandom_range(0, 9))
                0: issue_item(CMD_LOAD, 16'($urandom), 16'($urandom),
                              1'($urandom_range(0, 1)), 8'($urandom));
                1: issue_item(CMD_STEP, 16'($urandom), 16'($urandom),
                              1'($urandom_range(0, 1)), 8'($urandom));
                default:
                begin
                    ins = random_instr();
                    // place a data word where a pc-relative access lands
                    if ((ins[15:12] == OP_LD || ins[15:12] == OP_LDI ||
                         ins[15:12] == OP_STI) && ins[8:0] != 9'h1FF)
                    begin
                        dptr = cpu_pc + 16'd1 + {{7{ins[8]}}, ins[8:0]};
                        dval = ($urandom_range(0, 3) == 0) ? KBSR_ADDR : 16'($urandom);
                        if (dval == {OP_TRAP, 4'h0, TRAP_HALT})
                            dval = 16'h0000;
                        issue_item(CMD_LOAD, dptr, dval, 1'b0, 8'h00);
                    end
                    run_instr(ins, 1'($urandom_range(0, 1)), 8'($urandom));
                end
            endcase
        end

        // halt, then steps do nothing while loads still write
        run_instr({OP_TRAP, 4'h0, TRAP_HALT}, 1'b0, 8'h00);
        issue_item(CMD_STEP, 16'h0000, 16'h0000, 1'b1, 8'h55);
        issue_item(CMD_LOAD, cpu_pc, 16'h127F, 1'b0, 8'h00);
        issue_item(CMD_STEP, 16'h0000, 16'h0000, 1'b0, 8'h00);
        stimulus_built = 1'b1;
    end

    // reset
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // input side: sample the transfer at the rising edge
    logic s_fire;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_fire <= 1'b0;
        else
            s_fire <= s_tvalid && s_tready;
    end

    // input driver: bursts of idle cycles, none near the end
    int send_gap;
    always @(negedge clk or negedge rst_n)
    begin : drive_items
        logic next_valid;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap  = 0;
        end
        else if (stimulus_built)
        begin
            if (s_fire)
                void'(pending_items.pop_front());
            next_valid = s_tvalid && !s_fire;
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_items.size() > 0)
                begin
                    if (pending_items.size() > 120 && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 6) - 1;
                    else
                        next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
            if (next_valid)
                s_tdata <= pending_items[0];
        end
    end

    // result side: random bursts of stall, one long hold-off
    int recv_gap;
    int long_hold;
    logic long_hold_done;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready      <= 1'b0;
            recv_gap       = 0;
            long_hold      = 0;
            long_hold_done = 1'b0;
        end
        else if (long_hold > 0)
        begin
            long_hold--;
            m_tready <= 1'b0;
        end
        else if (!long_hold_done && accepted_results == 300)
        begin
            long_hold_done = 1'b1;
            long_hold      = 200;
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else if (expected_results.size() > 120 && $urandom_range(0, 5) == 0)
        begin
            recv_gap = $urandom_range(1, 6) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : check_results
        step_result_t want, got;
        if (!rst_n)
        begin
            mismatch_count   = 0;
            accepted_results = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            got = {m_tdata[15:0], m_tdata[18:16], m_tdata[19], m_tdata[27:20],
                   m_tdata[28], m_tdata[29]};
            accepted_results++;
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                if (got.pc != want.pc)
                    report_mismatch($sformatf("program_counter %h, want %h", got.pc, want.pc));
                if (got.cc != want.cc)
                    report_mismatch($sformatf("condition %h, want %h", got.cc, want.cc));
                if (got.ov != want.ov)
                    report_mismatch($sformatf("out_valid %b, want %b", got.ov, want.ov));
                if (got.oc != want.oc)
                    report_mismatch($sformatf("out_char %h, want %h", got.oc, want.oc));
                if (got.hlt != want.hlt)
                    report_mismatch($sformatf("halted %b, want %b", got.hlt, want.hlt));
                if (got.flt != want.flt)
                    report_mismatch($sformatf("fault %b, want %b", got.flt, want.flt));
            end
        end
    end

    // end of run
    initial
    begin
        wait (stimulus_built);
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog: clearing sweep plus several times the slowest run
    initial
    begin
        #(20.0 * 400000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
